### sv/sigwf_pkg.sv
`timescale 1ns / 1ps
package sigwf_pkg;

    // Field and counter widths fixed by the interface.
    localparam int PIX_W = 8;
    localparam int NCH = 3;
    localparam int CNT_W = 11;
    localparam int APB_AW = 4;
    localparam int REG_IDX_W = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_RADIUS = 3;
    localparam int DEF_MAX_WIDTH = 1024;

    // Register map (word index).
    localparam logic [REG_IDX_W-1:0] REG_SIGMA = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    // Reset values of the registers.
    localparam logic [7:0] RST_SIGMA = 8'd20;
    localparam logic [1:0] RST_RADIUS = 2'd1;
    localparam logic [CNT_W-1:0] RST_WIDTH = 11'd640;
    localparam logic [CNT_W-1:0] RST_HEIGHT = 11'd480;

    // Input kind carried on tuser.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

endpackage

### sv/sigma_window_filter_core.sv
`timescale 1ns / 1ps
// Sigma window filter for RGB pixels in raster order.
// Input stream: s_tdata carries one pixel, s_tuser says whether the transaction
// is a pixel or a drain tick. Each output pixel is the per-channel mean of the
// window values within sigma of the centre, the window clipped at the borders.
// The output for pixel p appears once pixel p + radius*width + radius has been
// taken; after the last pixel of a frame, one drain tick (or any transaction)
// flushes one pending output. m_tlast marks the last output of a frame.
// The user must write the configuration through the APB port only while the
// block is idle; the block itself does not enforce this. A pixel is written to
// the line store in the check state; the multiply and compare states then
// decide if an output is due. An output goes through setup, a sweep reading the
// window pixels (up to 49 at radius 3) one per cycle from the line store, the
// SUM_W divider cells (14 at radius 3) and the output state.
// One transaction is processed at a time; s_tready is high only while idle.
// A finished result waits in the output register while the next transaction
// is taken; if the receiver still stalls when that next result is ready, the
// block waits. Reset clears the counters and the registers to their defaults;
// the line store is not cleared.
module sigma_window_filter_core #(
    parameter int MAX_RADIUS = sigwf_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH = sigwf_pkg::DEF_MAX_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // red_in, green_in, blue_in
    input  logic                          s_tuser,   // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // red_out, green_out, blue_out
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sigwf_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import sigwf_pkg::*;

    localparam int RING = 2 * MAX_RADIUS + 2;
    localparam int RING_W = $clog2(RING);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW = $clog2(DEPTH);
    localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int ACC_W = $clog2(WIN_MAX + 1);
    localparam int SUM_W = $clog2(WIN_MAX * 255 + 1);
    localparam int ROWS_W = $clog2(2 * MAX_RADIUS + 1);
    localparam int LIN_W = 2 * CNT_W + 1;
    localparam int PXW = NCH * PIX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL = 3'd2;
    localparam logic [2:0] S_CMP = 3'd3;
    localparam logic [2:0] S_SETUP = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_DIV = 3'd6;
    localparam logic [2:0] S_OUT = 3'd7;

    function automatic logic [RING_W-1:0] ring_inc(input logic [RING_W-1:0] x);
        return (int'(x) == RING - 1) ? '0 : RING_W'(int'(x) + 1);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [RING_W-1:0] rg,
                                              input logic [CNT_W-1:0] col);
        return AW'(int'(rg) * MAX_WIDTH + int'(col));
    endfunction

    // Configuration registers.
    logic [7:0]       sigma_reg;
    logic [1:0]       radius_reg;
    logic [CNT_W-1:0] width_reg;
    logic [CNT_W-1:0] height_reg;
    logic             cfg_wr;

    // Frame counters and their ring row indexes.
    logic [CNT_W-1:0]  ir_reg, ic_reg, or_reg, oc_reg;
    logic [RING_W-1:0] irr_reg, orr_reg;
    logic [CNT_W-1:0]  ir_next, ic_next, or_next, oc_next;
    logic [RING_W-1:0] irr_next, orr_next;

    logic [2:0]       state_reg, state_next;
    logic             mode_reg;
    logic [PXW-1:0]   pix_reg;
    logic [LIN_W-1:0] prod_in_reg, prod_out_reg, prod_rad_reg;
    logic             last_reg, last_next;

    // Window sweep.
    logic [RING_W-1:0] sw_ring_reg, sw_ring_next;
    logic [CNT_W-1:0]  sw_col_reg, sw_col_next;
    logic [ROWS_W-1:0] rows_left_reg, rows_left_next;
    logic [CNT_W-1:0]  c0_reg, c0_next, c1_reg, c1_next;
    logic              sweep_done;

    // Read data pipeline and accumulators.
    logic                  rd_ctr_q, rd_win_q, rd_last_q, launch_reg;
    logic [PXW-1:0]        mid_reg;
    logic [2:0][SUM_W-1:0] sum_reg;
    logic [2:0][ACC_W-1:0] cnt_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [PXW-1:0]        ram_rdata;

    logic                  div_valid;
    logic [2:0][SUM_W-1:0] div_quo;
    logic [PXW-1:0]        res_reg;

    logic             m_tvalid_reg;
    logic [PXW-1:0]   m_data_reg;
    logic             m_last_reg;
    logic             out_load;

    // Effective register values and geometry helpers.
    logic [CNT_W-1:0] w_eff, h_eff, rad_w;
    logic [1:0]       rad_eff;
    logic [CNT_W:0]   or_plus, oc_plus;
    logic [CNT_W-1:0] r0, r1, c0g, c1g;
    logic [RING_W-1:0] r0_ring;
    logic [LIN_W-1:0] recv_lin, need_lin;
    logic             accept;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg <= RST_SIGMA;
            radius_reg <= RST_RADIUS;
            width_reg <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SIGMA:  sigma_reg <= pwdata[7:0];
                REG_RADIUS: radius_reg <= pwdata[1:0];
                REG_WIDTH:  width_reg <= pwdata[CNT_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SIGMA:  prdata = {24'd0, sigma_reg};
            REG_RADIUS: prdata = {30'd0, radius_reg};
            REG_WIDTH:  prdata = {21'd0, width_reg};
            REG_HEIGHT: prdata = {21'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (width_reg == '0) begin
            w_eff = CNT_W'(1);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? CNT_W'(1) : height_reg;
        rad_eff = (int'(radius_reg) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_reg;
        rad_w = CNT_W'(rad_eff);
    end

    // Clipped window bounds of the output pixel about to be produced.
    always_comb begin
        or_plus = {1'b0, or_reg} + {1'b0, rad_w};
        oc_plus = {1'b0, oc_reg} + {1'b0, rad_w};
        r0 = (or_reg >= rad_w) ? CNT_W'(or_reg - rad_w) : '0;
        c0g = (oc_reg >= rad_w) ? CNT_W'(oc_reg - rad_w) : '0;
        r1 = (or_plus < {1'b0, h_eff}) ? or_plus[CNT_W-1:0] : CNT_W'(h_eff - 1'b1);
        c1g = (oc_plus < {1'b0, w_eff}) ? oc_plus[CNT_W-1:0] : CNT_W'(w_eff - 1'b1);
        if (or_reg < rad_w) begin
            r0_ring = '0;
        end else if (int'(orr_reg) >= int'(rad_eff)) begin
            r0_ring = RING_W'(int'(orr_reg) - int'(rad_eff));
        end else begin
            r0_ring = RING_W'(int'(orr_reg) + RING - int'(rad_eff));
        end
    end

    assign recv_lin = prod_in_reg + LIN_W'(ic_reg);
    assign need_lin = prod_out_reg + LIN_W'(oc_reg) + prod_rad_reg + LIN_W'(rad_eff)
                      + LIN_W'(1);

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign sweep_done = (sw_col_reg == c1_reg) && (rows_left_reg == '0);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        ir_next = ir_reg;
        ic_next = ic_reg;
        or_next = or_reg;
        oc_next = oc_reg;
        irr_next = irr_reg;
        orr_next = orr_reg;
        last_next = last_reg;
        sw_ring_next = sw_ring_reg;
        sw_col_next = sw_col_reg;
        rows_left_next = rows_left_reg;
        c0_next = c0_reg;
        c1_next = c1_reg;
        ram_we = 1'b0;
        ram_waddr = addr_of(irr_reg, ic_reg);
        ram_raddr = addr_of(sw_ring_reg, sw_col_reg);
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // Counters left at the row end by a narrower width wrap here.
                    if (ic_reg >= w_eff) begin
                        ic_next = '0;
                        ir_next = ir_reg + 1'b1;
                        irr_next = ring_inc(irr_reg);
                    end
                    if (oc_reg >= w_eff) begin
                        oc_next = '0;
                        or_next = or_reg + 1'b1;
                        orr_next = ring_inc(orr_reg);
                    end
                    if (or_next >= h_eff) begin
                        ir_next = '0;
                        ic_next = '0;
                        or_next = '0;
                        oc_next = '0;
                        irr_next = '0;
                        orr_next = '0;
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (ir_reg >= h_eff) begin
                    state_next = S_SETUP;
                end else if (mode_reg == MODE_DRAIN) begin
                    state_next = S_IDLE;
                end else begin
                    ram_we = 1'b1;
                    if (ic_reg + 1'b1 >= w_eff) begin
                        ic_next = '0;
                        ir_next = ir_reg + 1'b1;
                        irr_next = ring_inc(irr_reg);
                    end else begin
                        ic_next = ic_reg + 1'b1;
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                state_next = (recv_lin >= need_lin) ? S_SETUP : S_IDLE;
            end
            S_SETUP: begin
                ram_raddr = addr_of(orr_reg, oc_reg);
                sw_ring_next = r0_ring;
                sw_col_next = c0g;
                c0_next = c0g;
                c1_next = c1g;
                rows_left_next = ROWS_W'(r1 - r0);
                last_next = 1'b0;
                if (oc_reg + 1'b1 >= w_eff) begin
                    oc_next = '0;
                    or_next = or_reg + 1'b1;
                    orr_next = ring_inc(orr_reg);
                end else begin
                    oc_next = oc_reg + 1'b1;
                end
                if (or_next >= h_eff) begin
                    last_next = 1'b1;
                    ir_next = '0;
                    ic_next = '0;
                    or_next = '0;
                    oc_next = '0;
                    irr_next = '0;
                    orr_next = '0;
                end
                state_next = S_SWEEP;
            end
            S_SWEEP: begin
                if (sw_col_reg == c1_reg) begin
                    sw_col_next = c0_reg;
                    if (rows_left_reg != '0) begin
                        rows_left_next = rows_left_reg - 1'b1;
                        sw_ring_next = ring_inc(sw_ring_reg);
                    end
                end else begin
                    sw_col_next = sw_col_reg + 1'b1;
                end
                if (sweep_done) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_valid) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ir_reg <= '0;
            ic_reg <= '0;
            or_reg <= '0;
            oc_reg <= '0;
            irr_reg <= '0;
            orr_reg <= '0;
            rd_ctr_q <= 1'b0;
            rd_win_q <= 1'b0;
            rd_last_q <= 1'b0;
            launch_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ir_reg <= ir_next;
            ic_reg <= ic_next;
            or_reg <= or_next;
            oc_reg <= oc_next;
            irr_reg <= irr_next;
            orr_reg <= orr_next;
            rd_ctr_q <= (state_reg == S_SETUP);
            rd_win_q <= (state_reg == S_SWEEP);
            rd_last_q <= (state_reg == S_SWEEP) && sweep_done;
            launch_reg <= rd_last_q;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
        sw_ring_reg <= sw_ring_next;
        sw_col_reg <= sw_col_next;
        rows_left_reg <= rows_left_next;
        c0_reg <= c0_next;
        c1_reg <= c1_next;
        if (accept) begin
            mode_reg <= s_tuser;
            pix_reg <= s_tdata;
        end
        prod_in_reg <= LIN_W'(ir_reg) * LIN_W'(w_eff);
        prod_out_reg <= LIN_W'(or_reg) * LIN_W'(w_eff);
        prod_rad_reg <= LIN_W'(rad_w) * LIN_W'(w_eff);
        if (rd_ctr_q) begin
            mid_reg <= ram_rdata;
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (rd_win_q) begin
            for (int ch = 0; ch < NCH; ch++) begin
                if (((ram_rdata[ch*PIX_W +: PIX_W] > mid_reg[ch*PIX_W +: PIX_W])
                        ? (ram_rdata[ch*PIX_W +: PIX_W] - mid_reg[ch*PIX_W +: PIX_W])
                        : (mid_reg[ch*PIX_W +: PIX_W] - ram_rdata[ch*PIX_W +: PIX_W]))
                        <= sigma_reg) begin
                    sum_reg[ch] <= sum_reg[ch] + SUM_W'(ram_rdata[ch*PIX_W +: PIX_W]);
                    cnt_reg[ch] <= cnt_reg[ch] + 1'b1;
                end
            end
        end
        if (div_valid) begin
            for (int ch = 0; ch < NCH; ch++) begin
                res_reg[ch*PIX_W +: PIX_W] <= div_quo[ch][PIX_W-1:0];
            end
        end
        if (out_load) begin
            m_data_reg <= res_reg;
            m_last_reg <= last_reg;
        end
    end

    sigwf_ram #(
        .WIDTH(PXW),
        .DEPTH(DEPTH)
    ) u_line_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(pix_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    sigwf_divider #(
        .SUM_W(SUM_W),
        .DIV_W(ACC_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (launch_reg),
        .in_sum   (sum_reg),
        .in_cnt   (cnt_reg),
        .out_valid(div_valid),
        .out_quo  (div_quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;

    // A quotient only leaves the divider while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid |-> state_reg == S_DIV)
        else $error("divider result outside the divide phase");

    // The line store is only written while a pixel is below the frame height.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CHECK) && (ir_reg < h_eff))
        else $error("line store written out of sequence");

    // A new output appears only from the output phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && $past(state_reg) == S_OUT)
        else $error("output register loaded out of sequence");

    // The window read pipeline finishes before the divider is started.
    assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg |-> $past(rd_last_q) && !rd_win_q)
        else $error("divider launched during window sweep");

endmodule

### sv/sigwf_ram.sv
`timescale 1ns / 1ps
module sigwf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/sigwf_div_cell.sv
`timescale 1ns / 1ps
module sigwf_div_cell #(
    parameter int SUM_W = 14,
    parameter int DIV_W = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [2:0][DIV_W-1:0]     in_rem,
    input  logic [2:0][SUM_W-1:0]     in_dvd,
    input  logic [2:0][SUM_W-1:0]     in_quo,
    input  logic [2:0][DIV_W-1:0]     in_div,
    output logic                      out_valid,
    output logic [2:0][DIV_W-1:0]     out_rem,
    output logic [2:0][SUM_W-1:0]     out_dvd,
    output logic [2:0][SUM_W-1:0]     out_quo,
    output logic [2:0][DIV_W-1:0]     out_div
);

    logic [2:0][DIV_W:0]   trial;
    logic [2:0][DIV_W-1:0] rem_next;
    logic [2:0]            qbit;

    // One restoring division step per lane: shift in the next dividend bit.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            trial[i] = {in_rem[i], in_dvd[i][SUM_W-1]};
            if (trial[i] >= {1'b0, in_div[i]}) begin
                qbit[i] = 1'b1;
                rem_next[i] = DIV_W'(trial[i] - {1'b0, in_div[i]});
            end else begin
                qbit[i] = 1'b0;
                rem_next[i] = trial[i][DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else begin
            out_valid <= in_valid;
        end
        for (int i = 0; i < 3; i++) begin
            out_rem[i] <= rem_next[i];
            out_dvd[i] <= {in_dvd[i][SUM_W-2:0], 1'b0};
            out_quo[i] <= {in_quo[i][SUM_W-2:0], qbit[i]};
            out_div[i] <= in_div[i];
        end
    end

endmodule

### sv/sigwf_divider.sv
`timescale 1ns / 1ps
module sigwf_divider #(
    parameter int SUM_W = 14,
    parameter int DIV_W = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [2:0][SUM_W-1:0] in_sum,
    input  logic [2:0][DIV_W-1:0] in_cnt,
    output logic                  out_valid,
    output logic [2:0][SUM_W-1:0] out_quo
);

    logic                  v   [SUM_W+1];
    logic [2:0][DIV_W-1:0] rem [SUM_W+1];
    logic [2:0][SUM_W-1:0] dvd [SUM_W+1];
    logic [2:0][SUM_W-1:0] quo [SUM_W+1];
    logic [2:0][DIV_W-1:0] dv  [SUM_W+1];

    assign v[0] = in_valid;
    assign rem[0] = '0;
    assign dvd[0] = in_sum;
    assign quo[0] = '0;
    assign dv[0] = in_cnt;

    // One cell per quotient bit; the operands move one cell each cycle.
    for (genvar k = 0; k < SUM_W; k++) begin : g_cell
        sigwf_div_cell #(
            .SUM_W(SUM_W),
            .DIV_W(DIV_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (v[k]),
            .in_rem   (rem[k]),
            .in_dvd   (dvd[k]),
            .in_quo   (quo[k]),
            .in_div   (dv[k]),
            .out_valid(v[k+1]),
            .out_rem  (rem[k+1]),
            .out_dvd  (dvd[k+1]),
            .out_quo  (quo[k+1]),
            .out_div  (dv[k+1])
        );
    end

    assign out_valid = v[SUM_W];
    assign out_quo = quo[SUM_W];

endmodule

### tb/sigma_window_filter_core_checker.sv
`timescale 1ns / 1ps
module sigma_window_filter_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [sigwf_pkg::APB_AW-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending_count
);
    import sigwf_pkg::*;

    typedef struct packed {
        logic       last;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } filt_pixel_t;

    localparam int RING = 2 * DEF_MAX_RADIUS + 2;

    logic [23:0] line_mem [0:RING-1][0:DEF_MAX_WIDTH-1];
    logic [7:0]  sigma_q;
    logic [1:0]  radius_q;
    logic [CNT_W-1:0] width_q;
    logic [CNT_W-1:0] height_q;
    int unsigned in_row, in_col, out_row, out_col;
    filt_pixel_t expected_pixels[$];

    initial begin
        mismatch_count = 0;
        foreach (line_mem[i, j]) line_mem[i][j] = '0;
    end

    assign pending_count = expected_pixels.size();

    // Filters the pixel at the output position and advances the output counters.
    function automatic filt_pixel_t filter_pixel(int unsigned w, int unsigned h,
                                                 int unsigned rad);
        filt_pixel_t px;
        int unsigned r0, r1, c0, c1, m, v, d, sum, cnt;
        logic [7:0] chans [0:2];
        r0 = (out_row >= rad) ? out_row - rad : 0;
        r1 = (out_row + rad < h) ? out_row + rad : h - 1;
        c0 = (out_col >= rad) ? out_col - rad : 0;
        c1 = (out_col + rad < w) ? out_col + rad : w - 1;
        for (int ch = 0; ch < 3; ch++) begin
            m = line_mem[out_row % RING][out_col][8*ch +: 8];
            sum = 0;
            cnt = 0;
            for (int unsigned rr = r0; rr <= r1; rr++) begin
                for (int unsigned cc = c0; cc <= c1; cc++) begin
                    v = line_mem[rr % RING][cc][8*ch +: 8];
                    d = (v > m) ? v - m : m - v;
                    if (d <= sigma_q) begin
                        sum += v;
                        cnt++;
                    end
                end
            end
            if (cnt == 0) cnt = 1;
            chans[ch] = 8'((sum / cnt) & 255);
        end
        px.red = chans[0];
        px.green = chans[1];
        px.blue = chans[2];
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        px.last = 1'b0;
        if (out_row >= h) begin
            px.last = 1'b1;
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        end
        return px;
    endfunction

    // Returns 1 when the transaction yields a filtered pixel.
    function automatic bit advance_window(logic mode, logic [23:0] data,
                                          output filt_pixel_t px);
        int unsigned w, h, rad, received, out_lin;
        w = (width_q == 0) ? 1 : (width_q > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_q;
        h = (height_q == 0) ? 1 : height_q;
        rad = (radius_q > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : radius_q;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= h) begin
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        end
        // Once the whole frame is in, any transaction flushes one output.
        if (in_row >= h) begin
            px = filter_pixel(w, h, rad);
            return 1'b1;
        end
        if (mode == MODE_DRAIN) return 1'b0;
        line_mem[in_row % RING][in_col] = data;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        received = in_row * w + in_col;
        out_lin = out_row * w + out_col;
        if (received >= out_lin + rad * w + rad + 1) begin
            px = filter_pixel(w, h, rad);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        filt_pixel_t px;
        filt_pixel_t want;
        if (!aresetn) begin
            sigma_q <= RST_SIGMA;
            radius_q <= RST_RADIUS;
            width_q <= RST_WIDTH;
            height_q <= RST_HEIGHT;
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SIGMA:  sigma_q <= pwdata[7:0];
                    REG_RADIUS: radius_q <= pwdata[1:0];
                    REG_WIDTH:  width_q <= pwdata[CNT_W-1:0];
                    REG_HEIGHT: height_q <= pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (advance_window(s_tuser, s_tdata, px)) expected_pixels.push_back(px);
            end
            if (m_tvalid && m_tready) begin
                px = {m_tlast, m_tdata};
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected output pixel %h", $time, px);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (px.red !== want.red || px.green !== want.green
                        || px.blue !== want.blue || px.last !== want.last) begin
                        $display("%0t: expected r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
                                 $time, want.red, want.green, want.blue, want.last,
                                 px.red, px.green, px.blue, px.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

### tb/sigma_window_filter_core_test.sv
`timescale 1ns / 1ps
module sigma_window_filter_core_test;
    import sigwf_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int RANDOM_ITEMS = 480;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;   // red_in, green_in, blue_in
    logic s_tuser = MODE_PIXEL;  // mode
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;        // red_out, green_out, blue_out
    logic m_tlast;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    int mismatch_count;
    int pending_count;
    int send_idle_pct = 33;
    int recv_idle_pct = 58;
    bit hold_req = 1'b0;
    int pixels_sent = 0;
    int cycles = 0;

    always #10 aclk = ~aclk;

    sigma_window_filter_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sigma_window_filter_core_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatch_count(mismatch_count), .pending_count(pending_count)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Entered and left at a falling edge with no assignment made yet.
    task automatic send_item(logic mode, logic [23:0] data);
        if ($urandom_range(99) < send_idle_pct) begin
            repeat ($urandom_range(3, 1)) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        // Transactions without a result may still be in flight.
        repeat (12) @(negedge aclk);
    endtask

    // One well-formed frame with random content; noise adds ignored drain ticks.
    task automatic run_frame(int sig, int rad, int wv, int hv, bit noise,
                             bit extremes);
        int w, h, n, flush;
        logic [23:0] px;
        wait_idle();
        write_reg(REG_SIGMA, sig);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_WIDTH, wv);
        write_reg(REG_HEIGHT, hv);
        w = (wv == 0) ? 1 : (wv > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : wv;
        h = (hv == 0) ? 1 : hv;
        n = w * h;
        flush = (rad * w + rad < n) ? rad * w + rad : n;
        for (int i = 0; i < n; i++) begin
            if (noise && $urandom_range(19) == 0)
                send_item(MODE_DRAIN, $urandom());
            px = $urandom();
            if (extremes) px = ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h000000;
            send_item(MODE_PIXEL, px);
            pixels_sent++;
        end
        // A pixel past the frame end acts as a drain tick.
        for (int i = 0; i < flush; i++) begin
            if ($urandom_range(4) == 0) send_item(MODE_PIXEL, $urandom());
            else send_item(MODE_DRAIN, $urandom());
            pixels_sent++;
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: tiny frames with extreme values, ignored drains, all radii.
        run_frame(20, 1, 3, 2, 1'b1, 1'b1);
        run_frame(255, 0, 1, 1, 1'b0, 1'b1);
        run_frame(0, 3, 2, 2, 1'b1, 1'b0);
        run_frame(128, 2, 3, 1, 1'b0, 1'b1);
        run_frame(0, 0, 0, 0, 1'b0, 1'b0);
        // Size extremes, and out-of-range sizes.
        run_frame(40, 0, 2047, 0, 1'b0, 1'b0);
        run_frame(255, 3, 0, 40, 1'b0, 1'b0);

        pixels_sent = 0;
        while (pixels_sent < RANDOM_ITEMS) begin
            if (pixels_sent > RANDOM_ITEMS / 3 && send_idle_pct == 33) begin
                send_idle_pct = 58;
                recv_idle_pct = 33;
            end else if (pixels_sent > 2 * RANDOM_ITEMS / 3 && send_idle_pct == 58) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req = 1'b1;
            end
            run_frame($urandom_range(255), $urandom_range(3), $urandom_range(12, 1),
                      $urandom_range(8, 1), $urandom_range(3) == 0, 1'b0);
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
sv/sigwf_pkg.sv
sv/sigwf_ram.sv
sv/sigwf_div_cell.sv
sv/sigwf_divider.sv
sv/sigma_window_filter_core.sv
tb/sigma_window_filter_core_checker.sv
tb/sigma_window_filter_core_test.sv
